// ===== rtl/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and constants of the response frame checker
// Request and result structs, frame phase, command and verdict codes, and the
// byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NODE_ADDRESS   = 2'd0;
  localparam logic [1:0] CFG_ACCEPT_MAX_LEN = 2'd1;
  localparam logic [1:0] CFG_CRC_START      = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  NODE_ADDRESS_RST   = 8'd0;
  localparam logic [7:0]  ACCEPT_MAX_LEN_RST = 8'd64;
  localparam logic [15:0] CRC_START_RST      = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    V_OK           = 3'd0,
    V_NO_RESPONSE  = 3'd1,
    V_INCOMPLETE   = 3'd2,
    V_BAD_RESPONSE = 3'd3,
    V_BAD_CRC      = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ADDR   = 3'd1,
    PH_STATUS = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic       is_final;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [2:0] verdict;
    logic [7:0] device_status;
    logic [7:0] payload_len;
  } res_t;

  typedef struct packed {
    logic [7:0]  node_address;
    logic [7:0]  accept_max_len;
    logic [15:0] crc_start;
  } cfg_t;

  // One byte into a reflected CRC-16, least significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'd0, data};
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/rfc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rfc_cfg_regs: configuration registers
// Node address, largest accepted length and CRC start value, written through
// a plain write port.
// ----------------------------------------------------------------------------
module rfc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output rfc_pkg::cfg_t cfg
);
  import rfc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address   <= NODE_ADDRESS_RST;
      cfg.accept_max_len <= ACCEPT_MAX_LEN_RST;
      cfg.crc_start      <= CRC_START_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ADDRESS:   cfg.node_address   <= cfg_data[7:0];
        CFG_ACCEPT_MAX_LEN: cfg.accept_max_len <= cfg_data[7:0];
        CFG_CRC_START:      cfg.crc_start      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rfc_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// rfc_frame_fsm: frame phase tracker and result former
// Advances the frame state on each accepted request and forms at most one
// result from it in the same cycle.
// ----------------------------------------------------------------------------
module rfc_frame_fsm #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  rfc_pkg::req_t req,
  input  rfc_pkg::cfg_t cfg,
  output logic          res_valid,
  output rfc_pkg::res_t res
);
  import rfc_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  phase_t      phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] crc_reg, crc_reg_next;
  logic [7:0]  held_status, held_status_next;
  logic [7:0]  held_len, held_len_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic        addr_bad, addr_bad_next;

  logic        active;
  logic        len_bad;
  logic        last_data;
  logic [15:0] crc_fed;
  logic [8:0]  count_inc;

  assign active    = (phase != PH_IDLE) && (phase != PH_DONE);
  assign len_bad   = addr_bad || (req.rx_byte > MaxLen) || (req.rx_byte > cfg.accept_max_len);
  assign crc_fed   = crc_feed(crc_reg, req.rx_byte);
  assign count_inc = {1'b0, byte_count} + 9'd1;
  assign last_data = count_inc >= {1'b0, held_len};

  // Next state.
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    crc_reg_next      = crc_reg;
    held_status_next  = held_status;
    held_len_next     = held_len;
    crc_low_byte_next = crc_low_byte;
    addr_bad_next     = addr_bad;
    unique case (command_t'(req.command))
      CMD_BEGIN: begin
        phase_next        = PH_ADDR;
        byte_count_next   = 8'd0;
        crc_reg_next      = cfg.crc_start;
        held_status_next  = 8'd0;
        held_len_next     = 8'd0;
        crc_low_byte_next = 8'd0;
        addr_bad_next     = 1'b0;
      end
      CMD_TIMEOUT: begin
        if (active) begin
          phase_next = PH_DONE;
        end
      end
      CMD_BYTE: begin
        unique case (phase)
          PH_ADDR: begin
            addr_bad_next = req.rx_byte != cfg.node_address;
            crc_reg_next  = crc_fed;
            phase_next    = PH_STATUS;
          end
          PH_STATUS: begin
            held_status_next = req.rx_byte;
            crc_reg_next     = crc_fed;
            phase_next       = PH_LEN;
          end
          PH_LEN: begin
            if (len_bad) begin
              phase_next = PH_DONE;
            end else begin
              held_len_next   = req.rx_byte;
              crc_reg_next    = crc_fed;
              byte_count_next = 8'd0;
              phase_next      = (req.rx_byte != 8'd0) ? PH_DATA : PH_CRC_LO;
            end
          end
          PH_DATA: begin
            crc_reg_next    = crc_fed;
            byte_count_next = count_inc[7:0];
            if (last_data) begin
              phase_next = PH_CRC_LO;
            end
          end
          PH_CRC_LO: begin
            crc_low_byte_next = req.rx_byte;
            phase_next        = PH_CRC_HI;
          end
          PH_CRC_HI: phase_next = PH_DONE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result for this request.
  always_comb begin
    res_valid         = 1'b0;
    res               = '0;
    res.device_status = held_status;
    res.payload_len   = held_len;
    unique case (command_t'(req.command))
      CMD_TIMEOUT: begin
        if (active) begin
          res_valid    = in_fire;
          res.is_final = 1'b1;
          res.verdict  = (phase == PH_ADDR) ? V_NO_RESPONSE : V_INCOMPLETE;
        end
      end
      CMD_BYTE: begin
        unique case (phase)
          PH_LEN: begin
            if (len_bad) begin
              res_valid    = in_fire;
              res.is_final = 1'b1;
              res.verdict  = V_BAD_RESPONSE;
            end
          end
          PH_DATA: begin
            res_valid      = in_fire;
            res.data_byte  = req.rx_byte;
            res.data_index = byte_count;
          end
          PH_CRC_HI: begin
            res_valid    = in_fire;
            res.is_final = 1'b1;
            res.verdict  = ({req.rx_byte, crc_low_byte} == crc_reg) ? V_OK : V_BAD_CRC;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= 8'd0;
      crc_reg      <= CRC_START_RST;
      held_status  <= 8'd0;
      held_len     <= 8'd0;
      crc_low_byte <= 8'd0;
      addr_bad     <= 1'b0;
    end else if (in_fire) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      crc_reg      <= crc_reg_next;
      held_status  <= held_status_next;
      held_len     <= held_len_next;
      crc_low_byte <= crc_low_byte_next;
      addr_bad     <= addr_bad_next;
    end
  end

  a_data_only_in_data_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.is_final) |-> (phase == PH_DATA))
    else $error("data result outside the data phase");

  a_final_closes_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_final) |=> (phase == PH_DONE))
    else $error("final verdict did not close the frame");

  a_quiet_when_closed: assert property (@(posedge clk) disable iff (rst)
    (!active) |-> !res_valid)
    else $error("result from a closed frame");

  a_index_below_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (byte_count < held_len))
    else $error("data index ran past the announced length");

endmodule

// ===== rtl/rfc_out_buf.sv =====
// ----------------------------------------------------------------------------
// rfc_out_buf: two-entry result buffer
// Holds results so a new request can be taken while one still waits.
// ----------------------------------------------------------------------------
module rfc_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfc_pkg::res_t push_res,
  output logic          has_room,
  output logic          out_valid,
  input  logic          out_ready,
  output rfc_pkg::res_t out_res
);
  import rfc_pkg::*;

  logic [1:0] count;
  res_t       head;
  res_t       tail;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign has_room  = count != 2'd2;
  assign out_res   = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        head <= push_res;
      end else begin
        tail <= push_res;
      end
    end else if (pop && !push) begin
      head <= tail;
    end else if (pop && push) begin
      // Only possible with one entry held, so the new result becomes the head.
      head <= push_res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push)
    else $error("result pushed into a full buffer");

  a_tail_moves_up: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && pop) |=> (out_valid && out_res == $past(tail)))
    else $error("second result lost after pop");

endmodule

// ===== rtl/response_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// response_frame_checker_core: reply frame checker with CRC-16 check
// Tracks one reply frame from a serial bus node and reports its data bytes
// and its final verdict.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_ready with in_req carrying a command
// (begin, received byte or timeout) and the received byte. A begin arms the
// checker for a new reply; bytes then walk through address, status, length,
// data and the two CRC bytes (low byte first). Each data byte yields one
// result on out_valid/out_ready; a frame not dropped by a new begin ends in
// one final verdict: ok, no response, incomplete, bad response or bad CRC.
// After the verdict, bytes and timeouts are dropped until the next begin.
// The configuration port writes node address, largest accepted length and
// CRC start value; write it only while no request is in flight.
// A result is visible on out_res the cycle after its request is accepted,
// when no older result still waits in the buffer.
// Throughput is one request per cycle while the result buffer has room;
// the CRC update of one byte is the longest path between request and buffer.
// Results go into a two-entry buffer, so a request is still taken while one
// result waits; in_ready falls only when both entries are full.
// Synchronous reset returns the frame to idle, empties the buffer and loads
// the configuration reset values.
// ----------------------------------------------------------------------------
module response_frame_checker_core #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  rfc_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output rfc_pkg::res_t out_res
);
  import rfc_pkg::*;

  cfg_t cfg;
  logic in_fire;
  logic res_valid;
  res_t res;

  // A request is taken whenever the result buffer has a free entry, even if
  // this request ends up producing no result.
  assign in_fire = in_valid && in_ready;

  rfc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfc_frame_fsm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_frame_fsm (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .req       (in_req),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  rfc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the response frame checker
// Plans reply frames (good, corrupted, truncated, misaddressed, oversized)
// under several register settings, drives them as requests with random bursts
// and gaps, stalls the result side, and compares every result against a
// frame tracker that follows each accepted request.
// ----------------------------------------------------------------------------
module tb_top;

  import rfc_pkg::*;

  localparam int          MAX_PAYLOAD   = 64;
  localparam int          RANDOM_ITEMS  = 900;
  localparam int          PHASE_ITEMS   = 120;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          CYCLE_LIMIT   = 400000;
  // The command code that the block must ignore.
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;

  typedef enum logic [1:0] {
    ST_REQUEST,
    ST_REG_WRITE,
    ST_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t   kind;
    req_t         req;
    logic [1:0]   reg_index;
    logic [15:0]  reg_value;
  } plan_step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_NODE_ADDRESS;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_res;

  response_frame_checker_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res(out_res)
  );

  always #2 clk = ~clk;

  // Stimulus plan, filled up front and consumed by the driver.
  plan_step_t pending_steps[$];
  // Results the frame tracker says the block owes, oldest first.
  res_t       expected_results[$];
  int         error_count = 0;
  int         planned_items = 0;
  int         cycle_count = 0;

  // Register values as the plan will have written them; used to build
  // frames that get past the header checks.
  logic [7:0]  plan_node = NODE_ADDRESS_RST;
  logic [7:0]  plan_max_len = ACCEPT_MAX_LEN_RST;
  logic [15:0] plan_crc_start = CRC_START_RST;

  // Frame tracker: register copies and the state of the open reply.
  logic [7:0]  trk_node;
  logic [7:0]  trk_max_len;
  logic [15:0] trk_crc_start;
  phase_t      trk_phase;
  logic [7:0]  trk_count;
  logic [15:0] trk_crc;
  logic [7:0]  trk_status;
  logic [7:0]  trk_len;
  logic [7:0]  trk_crc_lo;
  logic        trk_addr_bad;

  // Reflected CRC-16 advanced one bit at a time, with the data bit folded into
  // the feedback instead of being XORed into the register up front.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ((r[0] ^ octet[k]) ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // Largest length the header check lets through under the planned settings.
  function automatic logic [7:0] accept_limit();
    return (plan_max_len < 8'(MAX_PAYLOAD)) ? plan_max_len : 8'(MAX_PAYLOAD);
  endfunction

  // Follows one accepted request through the frame and queues the result it
  // causes, if any.
  task automatic advance_frame(input req_t r);
    res_t     res;
    verdict_t v;
    bit       closing;
    bit       produced;
    res = '0;
    v = V_OK;
    closing = 1'b0;
    produced = 1'b0;
    if (r.command == CMD_BEGIN) begin
      // A begin always rearms, dropping any open frame without a verdict.
      trk_phase = PH_ADDR;
      trk_count = 8'd0;
      trk_crc = trk_crc_start;
      trk_status = 8'd0;
      trk_len = 8'd0;
      trk_crc_lo = 8'd0;
      trk_addr_bad = 1'b0;
    end else if (trk_phase == PH_IDLE || trk_phase == PH_DONE) begin
      // Nothing open: bytes, timeouts and the unused code are dropped.
    end else if (r.command == CMD_TIMEOUT) begin
      closing = 1'b1;
      v = (trk_phase == PH_ADDR) ? V_NO_RESPONSE : V_INCOMPLETE;
    end else if (r.command == CMD_BYTE) begin
      case (trk_phase)
        PH_ADDR: begin
          // The address is only judged together with the length byte.
          trk_addr_bad = (r.rx_byte != trk_node);
          trk_crc = crc16_step(trk_crc, r.rx_byte);
          trk_phase = PH_STATUS;
        end
        PH_STATUS: begin
          trk_status = r.rx_byte;
          trk_crc = crc16_step(trk_crc, r.rx_byte);
          trk_phase = PH_LEN;
        end
        PH_LEN: begin
          if (trk_addr_bad || r.rx_byte > 8'(MAX_PAYLOAD) || r.rx_byte > trk_max_len) begin
            closing = 1'b1;
            v = V_BAD_RESPONSE;
          end else begin
            trk_len = r.rx_byte;
            trk_crc = crc16_step(trk_crc, r.rx_byte);
            trk_count = 8'd0;
            // A zero length goes straight on to the CRC bytes.
            trk_phase = (r.rx_byte != 8'd0) ? PH_DATA : PH_CRC_LO;
          end
        end
        PH_DATA: begin
          trk_crc = crc16_step(trk_crc, r.rx_byte);
          res.is_final = 1'b0;
          res.data_byte = r.rx_byte;
          res.data_index = trk_count;
          res.verdict = V_OK;
          res.device_status = trk_status;
          res.payload_len = trk_len;
          produced = 1'b1;
          trk_count = trk_count + 8'd1;
          if (trk_count >= trk_len) begin
            trk_phase = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          trk_crc_lo = r.rx_byte;
          trk_phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          closing = 1'b1;
          v = ({r.rx_byte, trk_crc_lo} == trk_crc) ? V_OK : V_BAD_CRC;
        end
        default: begin
        end
      endcase
    end
    if (closing) begin
      res.is_final = 1'b1;
      res.data_byte = 8'd0;
      res.data_index = 8'd0;
      res.verdict = v;
      res.device_status = trk_status;
      res.payload_len = trk_len;
      produced = 1'b1;
      trk_phase = PH_DONE;
    end
    if (produced) begin
      expected_results.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------- planning

  task automatic push_req(input logic [1:0] cmd, input logic [7:0] octet);
    plan_step_t s;
    s.kind = ST_REQUEST;
    s.req.command = cmd;
    s.req.rx_byte = octet;
    s.reg_index = CFG_NODE_ADDRESS;
    s.reg_value = 16'd0;
    pending_steps.push_back(s);
    planned_items++;
  endtask

  // Waits for the block to go quiet, then writes all three registers.
  task automatic set_config(input logic [7:0] node, input logic [7:0] max_len,
                            input logic [15:0] start);
    plan_step_t s;
    s.req = '0;
    s.kind = ST_DRAIN;
    s.reg_index = CFG_NODE_ADDRESS;
    s.reg_value = 16'd0;
    pending_steps.push_back(s);
    s.kind = ST_REG_WRITE;
    s.reg_index = CFG_NODE_ADDRESS;
    s.reg_value = {8'd0, node};
    pending_steps.push_back(s);
    s.reg_index = CFG_ACCEPT_MAX_LEN;
    s.reg_value = {8'd0, max_len};
    pending_steps.push_back(s);
    s.reg_index = CFG_CRC_START;
    s.reg_value = start;
    pending_steps.push_back(s);
    plan_node = node;
    plan_max_len = max_len;
    plan_crc_start = start;
  endtask

  // Plans a begin and one reply. When cut is in range, only that many bytes
  // are sent, followed by a timeout or by nothing (the next begin drops it).
  task automatic plan_reply(input logic [7:0] addr, input logic [7:0] status,
                            input logic [7:0] len, input int cut,
                            input bit close_by_timeout, input bit corrupt);
    logic [7:0]  octets[$];
    logic [15:0] sum;
    int          n_data;
    octets = {addr, status, len};
    // A header that is rejected gets only a few trailing bytes.
    n_data = (addr == plan_node && len <= accept_limit()) ? int'(len)
                                                          : int'($urandom_range(0, 3));
    for (int i = 0; i < n_data; i++) begin
      octets.push_back(8'($urandom));
    end
    sum = plan_crc_start;
    foreach (octets[i]) begin
      sum = crc16_step(sum, octets[i]);
    end
    if (corrupt) begin
      sum = sum ^ 16'($urandom_range(1, 65535));
    end
    octets.push_back(sum[7:0]);
    octets.push_back(sum[15:8]);
    push_req(CMD_BEGIN, 8'($urandom));
    if (cut >= 0 && cut < octets.size()) begin
      for (int i = 0; i < cut; i++) begin
        push_req(CMD_BYTE, octets[i]);
      end
      if (close_by_timeout) begin
        push_req(CMD_TIMEOUT, 8'($urandom));
      end
    end else begin
      foreach (octets[i]) begin
        push_req(CMD_BYTE, octets[i]);
      end
    end
  endtask

  // Mostly well-formed replies with random content and short lengths, with
  // a share of wrong addresses, oversized lengths, bad CRCs, truncation and
  // stray requests between frames.
  task automatic random_reply();
    logic [7:0] addr;
    logic [7:0] lim;
    logic [7:0] len;
    int         pick;
    int         cut;
    int         n_noise;
    lim = accept_limit();
    addr = ($urandom_range(0, 11) == 0) ? 8'($urandom) : plan_node;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      len = 8'($urandom_range(0, (lim < 8'd8) ? lim : 8'd8));
    end else if (pick < 16) begin
      len = 8'($urandom_range(0, lim));
    end else if (pick < 17) begin
      len = lim;
    end else begin
      len = 8'($urandom);
    end
    cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, int'(len) + 4)) : -1;
    plan_reply(addr, 8'($urandom), len, cut, 1'($urandom_range(0, 1)),
               $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 5) == 0) begin
      n_noise = $urandom_range(1, 3);
      for (int i = 0; i < n_noise; i++) begin
        pick = $urandom_range(0, 2);
        push_req((pick == 0) ? CMD_BYTE : (pick == 1) ? CMD_TIMEOUT : CMD_UNUSED,
                 8'($urandom));
      end
    end
  endtask

  // ------------------------------------------------------------------ driver

  int  burst_left = 1;
  int  gap_left = 0;
  int  settle_left = SETTLE_CYCLES;
  logic req_taken = 1'b0;

  // Sender side. The valid stays up with a steady payload until the request
  // is taken; new requests come in bursts of random length with random gaps.
  // A drain step holds the sender until every expected result has come back
  // and a settle countdown has run out for any silent request to finish.
  always @(negedge clk) begin : drive_requests
    logic        nv;
    req_t        nreq;
    logic        nwe;
    logic [1:0]  nidx;
    logic [15:0] ndata;
    nv = in_valid;
    nreq = in_req;
    nwe = 1'b0;
    nidx = cfg_index;
    ndata = cfg_data;
    if (rst) begin
      nv = 1'b0;
    end else if (in_valid && !req_taken) begin
      nv = 1'b1;
    end else begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_steps.size() > 0) begin
        case (pending_steps[0].kind)
          ST_REQUEST: begin
            nv = 1'b1;
            nreq = pending_steps[0].req;
            void'(pending_steps.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
          ST_REG_WRITE: begin
            nwe = 1'b1;
            nidx = pending_steps[0].reg_index;
            ndata = pending_steps[0].reg_value;
            void'(pending_steps.pop_front());
          end
          default: begin
            if (expected_results.size() != 0) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left > 0) begin
              settle_left--;
            end else begin
              settle_left = SETTLE_CYCLES;
              void'(pending_steps.pop_front());
            end
          end
        endcase
      end
    end
    in_valid <= nv;
    in_req <= nreq;
    cfg_we <= nwe;
    cfg_index <= nidx;
    cfg_data <= ndata;
  end

  // Receiver side: switches between always ready, coin-flip ready and mostly
  // stalled, each for a random stretch of cycles.
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk) begin : drive_ready
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ----------------------------------------------------------------- monitor

  // Checks the result taken at this edge first, then registers a write and
  // follows the request taken at the same edge, so the order is fixed.
  always @(posedge clk) begin : watch_ports
    res_t want;
    if (rst) begin
      trk_node = NODE_ADDRESS_RST;
      trk_max_len = ACCEPT_MAX_LEN_RST;
      trk_crc_start = CRC_START_RST;
      trk_phase = PH_IDLE;
      trk_count = 8'd0;
      trk_crc = CRC_START_RST;
      trk_status = 8'd0;
      trk_len = 8'd0;
      trk_crc_lo = 8'd0;
      trk_addr_bad = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: is_final %0d verdict %0d data_byte %0d",
                 out_res.is_final, out_res.verdict, out_res.data_byte);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("is_final", 8'(want.is_final), 8'(out_res.is_final));
          check_field("data_byte", want.data_byte, out_res.data_byte);
          check_field("data_index", want.data_index, out_res.data_index);
          check_field("verdict", 8'(want.verdict), 8'(out_res.verdict));
          check_field("device_status", want.device_status, out_res.device_status);
          check_field("payload_len", want.payload_len, out_res.payload_len);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_ADDRESS:   trk_node = cfg_data[7:0];
          CFG_ACCEPT_MAX_LEN: trk_max_len = cfg_data[7:0];
          CFG_CRC_START:      trk_crc_start = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        advance_frame(in_req);
      end
    end
    req_taken <= !rst && in_valid && in_ready;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_test
    int phase_no;
    int phase_end;
    int random_start;

    // Directed frames under a known address.
    set_config(8'h5A, 8'd64, 16'hFFFF);
    push_req(CMD_TIMEOUT, 8'h00);                   // timeout while idle
    push_req(CMD_BYTE, 8'hFF);                      // byte while idle
    plan_reply(8'h5A, 8'h00, 8'd0, 0, 1'b1, 1'b0);  // timeout before any byte
    plan_reply(8'h5A, 8'h81, 8'd2, 1, 1'b1, 1'b0);  // timeout after the address
    plan_reply(8'h5A, 8'hFF, 8'd0, -1, 1'b0, 1'b0); // zero length, good CRC
    plan_reply(8'hA5, 8'h00, 8'd1, 3, 1'b1, 1'b0);  // wrong address
    plan_reply(8'h5A, 8'h00, 8'd255, 3, 1'b1, 1'b0); // length over the limit
    plan_reply(8'h5A, 8'h3C, 8'd4, 5, 1'b0, 1'b0);  // open after two data bytes
    push_req(CMD_UNUSED, 8'hA5);                    // unused code, frame open
    push_req(CMD_TIMEOUT, 8'h00);

    // Random frames, one register setting per phase; the first two phases
    // take the low and high extremes of every register.
    random_start = planned_items;
    phase_no = 0;
    while (planned_items - random_start < RANDOM_ITEMS) begin
      case (phase_no)
        0: set_config(8'h00, 8'h00, 16'h0000);
        1: set_config(8'hFF, 8'hFF, 16'hFFFF);
        2: set_config(8'($urandom), 8'd64, 16'($urandom));
        3: set_config(8'($urandom), 8'd63, 16'($urandom));
        default: set_config(8'($urandom), 8'($urandom), 16'($urandom));
      endcase
      phase_end = planned_items + PHASE_ITEMS;
      while (planned_items < phase_end && planned_items - random_start < RANDOM_ITEMS) begin
        random_reply();
      end
      // Close whatever frame is still open before the next register change.
      push_req(CMD_TIMEOUT, 8'($urandom));
      phase_no++;
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Every request out, then every result back, then a short settle time.
    do @(posedge clk); while (pending_steps.size() != 0 || in_valid);
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rfc_pkg.sv
rtl/rfc_cfg_regs.sv
rtl/rfc_frame_fsm.sv
rtl/rfc_out_buf.sv
rtl/response_frame_checker_core.sv
sim/tb_top.sv
